/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ARP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arp assertion failed");

// next-cycle implication
`define ARP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arp assertion failed");

`endif

/* hw/rtl/arp_pkg.sv */
// ----------------------------------------------------------------------------
// arp_pkg
// types, relocation type codes and result codes of the relocation patch unit
// ----------------------------------------------------------------------------
package arp_pkg;

    // relocation type numbers
    localparam logic [31:0] R_NONE              = 32'd0;
    localparam logic [31:0] R_NONE_ALT          = 32'd256;
    localparam logic [31:0] R_ABS64             = 32'd257;
    localparam logic [31:0] R_ABS32             = 32'd258;
    localparam logic [31:0] R_ABS16             = 32'd259;
    localparam logic [31:0] R_PREL64            = 32'd260;
    localparam logic [31:0] R_PREL32            = 32'd261;
    localparam logic [31:0] R_PREL16            = 32'd262;
    localparam logic [31:0] R_LD_PREL_LO19      = 32'd273;
    localparam logic [31:0] R_ADR_PREL_LO21     = 32'd274;
    localparam logic [31:0] R_ADR_PREL_PG_HI21  = 32'd275;
    localparam logic [31:0] R_ADR_PG_HI21_NC    = 32'd276;
    localparam logic [31:0] R_ADD_ABS_LO12_NC   = 32'd277;
    localparam logic [31:0] R_LDST8_ABS_LO12    = 32'd278;
    localparam logic [31:0] R_TSTBR14           = 32'd279;
    localparam logic [31:0] R_CONDBR19          = 32'd280;
    localparam logic [31:0] R_JUMP26            = 32'd282;
    localparam logic [31:0] R_CALL26            = 32'd283;
    localparam logic [31:0] R_LDST16_ABS_LO12   = 32'd284;
    localparam logic [31:0] R_LDST32_ABS_LO12   = 32'd285;
    localparam logic [31:0] R_LDST64_ABS_LO12   = 32'd286;
    localparam logic [31:0] R_LDST128_ABS_LO12  = 32'd299;

    // store widths
    localparam logic [1:0] SW_NONE = 2'd0;
    localparam logic [1:0] SW_16   = 2'd1;
    localparam logic [1:0] SW_32   = 2'd2;
    localparam logic [1:0] SW_64   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    localparam logic [63:0] PAGE_MASK = ~64'hfff;
    localparam int IMM_W = 26;

    typedef enum logic [1:0] {
        OP_ABS  = 2'd0,
        OP_PREL = 2'd1,
        OP_PAGE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        FLD_26  = 3'd0,
        FLD_19  = 3'd1,
        FLD_14  = 3'd2,
        FLD_12  = 3'd3,
        FLD_ADR = 3'd4
    } kind_t;

    typedef struct packed {
        logic       has_op;
        logic       data;
        op_t        op;
        logic [1:0] width;
        logic       chk32;
        logic       chk16;
        logic [3:0] lsb;
        logic [4:0] len;
        kind_t      kind;
        logic [1:0] status;
    } ctrl_t;

    typedef struct packed {
        ctrl_t        ctrl;
        logic [63:0]  sa;
        logic [63:0]  p;
        logic [31:0]  insn;
    } dec_t;

    typedef struct packed {
        ctrl_t        ctrl;
        logic [63:0]  x;
        logic [31:0]  insn;
    } calc_t;

    typedef struct packed {
        logic [63:0] patch_value;
        logic [1:0]  store_width;
        logic [1:0]  status;
    } res_t;

endpackage

/* hw/rtl/arp_entry_if.sv */
// ----------------------------------------------------------------------------
// arp_entry_if
// input channel: one relocation entry per request
// ----------------------------------------------------------------------------
interface arp_entry_if;
    logic        valid;
    logic        ready;
    logic [31:0] cmd;
    logic [63:0] target_value;
    logic [63:0] place_addr;
    logic [31:0] orig_insn;

    modport source (output valid, cmd, target_value, place_addr, orig_insn, input ready);
    modport sink   (input valid, cmd, target_value, place_addr, orig_insn, output ready);
    modport monitor (input valid, ready, cmd, target_value, place_addr, orig_insn);
endinterface

/* hw/rtl/arp_result_if.sv */
// ----------------------------------------------------------------------------
// arp_result_if
// output channel: one patch result per request
// ----------------------------------------------------------------------------
interface arp_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] patch_value;
    logic [1:0]  store_width;
    logic [1:0]  status;

    modport source (output valid, patch_value, store_width, status, input ready);
    modport sink   (input valid, patch_value, store_width, status, output ready);
    modport monitor (input valid, ready, patch_value, store_width, status);
endinterface

/* hw/rtl/arp_decode.sv */
// ----------------------------------------------------------------------------
// arp_decode
// stage 1: decodes the relocation type into operation, field and check controls
// ----------------------------------------------------------------------------
module arp_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [31:0]   cmd,
    input  logic [63:0]   target_value,
    input  logic [63:0]   place_addr,
    input  logic [31:0]   orig_insn,
    output logic          out_valid,
    input  logic          out_ready,
    output arp_pkg::dec_t out_data
);
    import arp_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    dec_t  data_reg;
    dec_t  data_next;
    ctrl_t ctrl;
    logic  load;

    always_comb
    begin
        ctrl        = '0;
        ctrl.op     = OP_ABS;
        ctrl.kind   = FLD_12;
        ctrl.width  = SW_NONE;
        ctrl.status = ST_OK;
        unique case (cmd) inside
            R_NONE, R_NONE_ALT:
            begin
            end
            R_ABS64:
            begin
                ctrl.has_op = 1'b1; ctrl.data = 1'b1; ctrl.width = SW_64;
            end
            R_ABS32:
            begin
                ctrl.has_op = 1'b1; ctrl.data = 1'b1; ctrl.width = SW_32; ctrl.chk32 = 1'b1;
            end
            R_ABS16:
            begin
                ctrl.has_op = 1'b1; ctrl.data = 1'b1; ctrl.width = SW_16; ctrl.chk16 = 1'b1;
            end
            R_PREL64:
            begin
                ctrl.has_op = 1'b1; ctrl.data = 1'b1; ctrl.op = OP_PREL; ctrl.width = SW_64;
            end
            R_PREL32:
            begin
                ctrl.has_op = 1'b1; ctrl.data = 1'b1; ctrl.op = OP_PREL;
                ctrl.width = SW_32; ctrl.chk32 = 1'b1;
            end
            R_PREL16:
            begin
                ctrl.has_op = 1'b1; ctrl.data = 1'b1; ctrl.op = OP_PREL;
                ctrl.width = SW_16; ctrl.chk16 = 1'b1;
            end
            R_LD_PREL_LO19, R_CONDBR19:
            begin
                ctrl.has_op = 1'b1; ctrl.op = OP_PREL;
                ctrl.len = 5'd19; ctrl.lsb = 4'd2; ctrl.kind = FLD_19;
            end
            R_ADR_PREL_LO21:
            begin
                ctrl.has_op = 1'b1; ctrl.op = OP_PREL;
                ctrl.len = 5'd21; ctrl.lsb = 4'd0; ctrl.kind = FLD_ADR;
            end
            R_ADR_PREL_PG_HI21:
            begin
                ctrl.has_op = 1'b1; ctrl.op = OP_PAGE; ctrl.chk32 = 1'b1;
                ctrl.len = 5'd21; ctrl.lsb = 4'd12; ctrl.kind = FLD_ADR;
            end
            R_ADR_PG_HI21_NC:
            begin
                ctrl.has_op = 1'b1; ctrl.op = OP_PAGE;
                ctrl.len = 5'd21; ctrl.lsb = 4'd12; ctrl.kind = FLD_ADR;
            end
            R_ADD_ABS_LO12_NC, R_LDST8_ABS_LO12:
            begin
                ctrl.has_op = 1'b1; ctrl.len = 5'd12; ctrl.lsb = 4'd0;
            end
            R_LDST16_ABS_LO12:
            begin
                ctrl.has_op = 1'b1; ctrl.len = 5'd11; ctrl.lsb = 4'd1;
            end
            R_LDST32_ABS_LO12:
            begin
                ctrl.has_op = 1'b1; ctrl.len = 5'd10; ctrl.lsb = 4'd2;
            end
            R_LDST64_ABS_LO12:
            begin
                ctrl.has_op = 1'b1; ctrl.len = 5'd9; ctrl.lsb = 4'd3;
            end
            R_LDST128_ABS_LO12:
            begin
                ctrl.has_op = 1'b1; ctrl.len = 5'd8; ctrl.lsb = 4'd4;
            end
            R_TSTBR14:
            begin
                ctrl.has_op = 1'b1; ctrl.op = OP_PREL;
                ctrl.len = 5'd14; ctrl.lsb = 4'd2; ctrl.kind = FLD_14;
            end
            R_JUMP26, R_CALL26:
            begin
                ctrl.has_op = 1'b1; ctrl.op = OP_PREL;
                ctrl.len = 5'd26; ctrl.lsb = 4'd2; ctrl.kind = FLD_26;
            end
            default:
            begin
                ctrl.status = ST_UNSUP;
            end
        endcase
    end

    assign in_ready = !vld_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign vld_next = load ? 1'b1 : (out_ready ? 1'b0 : vld_reg);

    always_comb
    begin
        data_next.ctrl = ctrl;
        data_next.sa   = target_value;
        data_next.p    = place_addr;
        data_next.insn = orig_insn;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

/* hw/rtl/arp_calc.sv */
// ----------------------------------------------------------------------------
// arp_calc
// stage 2: forms the absolute, pc-relative or page-relative value
// ----------------------------------------------------------------------------
module arp_calc (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  arp_pkg::dec_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output arp_pkg::calc_t out_data
);
    import arp_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    calc_t data_reg;
    calc_t data_next;
    logic  load;

    always_comb
    begin
        data_next.ctrl = in_data.ctrl;
        data_next.insn = in_data.insn;
        unique case (in_data.ctrl.op)
            OP_PREL: data_next.x = in_data.sa - in_data.p;
            OP_PAGE: data_next.x = (in_data.sa & PAGE_MASK) - (in_data.p & PAGE_MASK);
            default: data_next.x = in_data.sa;
        endcase
    end

    assign in_ready = !vld_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign vld_next = load ? 1'b1 : (out_ready ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

/* hw/rtl/arp_pack.sv */
// ----------------------------------------------------------------------------
// arp_pack
// stage 3: range check, store formatting and immediate field insert;
// its register is the output register of the block
// ----------------------------------------------------------------------------
module arp_pack (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  arp_pkg::calc_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output arp_pkg::res_t  out_data
);
    import arp_pkg::*;

    logic             vld_reg;
    logic             vld_next;
    res_t             data_reg;
    res_t             data_next;
    logic             load;
    logic             fit32;
    logic             fit16;
    logic             ovf;
    logic [37:0]      shifted;
    logic [IMM_W-1:0] imm;
    logic [IMM_W-1:0] len_mask;
    logic [31:0]      insn;

    assign fit32 = (&in_data.x[63:31]) || !(|in_data.x[63:31]);
    assign fit16 = (&in_data.x[63:15]) || !(|in_data.x[63:15]);
    assign ovf   = (in_data.ctrl.chk32 && !fit32) || (in_data.ctrl.chk16 && !fit16);

    assign shifted  = in_data.x[37:0] >> in_data.ctrl.lsb;
    assign len_mask = ~({IMM_W{1'b1}} << in_data.ctrl.len);
    assign imm      = shifted[IMM_W-1:0] & len_mask;

    always_comb
    begin
        insn = in_data.insn;
        case (in_data.ctrl.kind)
            FLD_26:  insn[25:0]  = imm[25:0];
            FLD_19:  insn[23:5]  = imm[18:0];
            FLD_14:  insn[18:5]  = imm[13:0];
            FLD_ADR:
            begin
                insn[30:29] = imm[1:0];
                insn[23:5]  = imm[20:2];
            end
            default: insn[21:10] = imm[11:0];
        endcase
    end

    always_comb
    begin
        data_next.patch_value = '0;
        data_next.store_width = in_data.ctrl.width;
        data_next.status      = in_data.ctrl.status;
        if (in_data.ctrl.has_op)
        begin
            if (ovf)
            begin
                data_next.status      = ST_RANGE;
                data_next.store_width = SW_NONE;
            end
            else if (in_data.ctrl.data)
            begin
                case (in_data.ctrl.width)
                    SW_16:   data_next.patch_value = {48'd0, in_data.x[15:0]};
                    SW_32:   data_next.patch_value = {32'd0, in_data.x[31:0]};
                    default: data_next.patch_value = in_data.x;
                endcase
            end
            else
            begin
                data_next.patch_value = {32'd0, insn};
                data_next.store_width = SW_32;
            end
        end
    end

    assign in_ready = !vld_reg || out_ready;
    assign load     = in_valid && in_ready;
    assign vld_next = load ? 1'b1 : (out_ready ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

/* hw/rtl/aarch64_reloc_patch_unit.sv */
// ----------------------------------------------------------------------------
// aarch64_reloc_patch_unit
// applies one aarch64 rela relocation per request and returns the patch
// ----------------------------------------------------------------------------
// Three-stage pipeline: decode, value calculation (one 64-bit subtract),
// then range check with store formatting or immediate insert. Every request
// gives exactly one result, held in turn by the decode, calc and pack stage
// registers. The sustained rate is one relocation per clock while the result
// channel is ready. Each stage holds its own valid bit; back-pressure on the
// result channel stalls the stages in place, and a request is still taken
// whenever some stage has room. No state survives between requests.
// ----------------------------------------------------------------------------
module aarch64_reloc_patch_unit (
    input logic          clk,
    input logic          rst_n,
    arp_entry_if.sink    entry,
    arp_result_if.source result
);
    import arp_pkg::*;

    logic  dec_valid;
    logic  dec_ready;
    dec_t  dec_data;
    logic  calc_valid;
    logic  calc_ready;
    calc_t calc_data;
    res_t  res_data;

    arp_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (entry.valid),
        .in_ready     (entry.ready),
        .cmd          (entry.cmd),
        .target_value (entry.target_value),
        .place_addr   (entry.place_addr),
        .orig_insn    (entry.orig_insn),
        .out_valid    (dec_valid),
        .out_ready    (dec_ready),
        .out_data     (dec_data)
    );

    arp_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (calc_valid),
        .out_ready (calc_ready),
        .out_data  (calc_data)
    );

    arp_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (calc_valid),
        .in_ready  (calc_ready),
        .in_data   (calc_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (res_data)
    );

    assign result.patch_value = res_data.patch_value;
    assign result.store_width = res_data.store_width;
    assign result.status      = res_data.status;

endmodule

/* hw/rtl/arp_checker.sv */
// ----------------------------------------------------------------------------
// arp_checker
// port-level checks of the relocation patch unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        entry_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [63:0] result_patch_value,
    input logic [1:0]  result_store_width,
    input logic [1:0]  result_status
);
    import arp_pkg::*;

    logic        stall;
    logic        err;
    logic [67:0] res_bits;
    logic        no_store;
    logic        st16;
    logic        st32;
    logic        st16_ok;
    logic        st32_ok;

    assign stall    = result_valid && !result_ready;
    assign err      = result_status == ST_RANGE || result_status == ST_UNSUP;
    assign res_bits = {result_patch_value, result_store_width, result_status};
    assign no_store = result_store_width == SW_NONE && result_patch_value == 64'd0;
    assign st16     = result_valid && result_store_width == SW_16;
    assign st32     = result_valid && result_store_width == SW_32;
    assign st16_ok  = result_patch_value[63:16] == 48'd0 && result_status == ST_OK;
    assign st32_ok  = result_patch_value[63:32] == 32'd0 && result_status == ST_OK;

    `ARP_ASSERT_NEXT(a_result_hold, stall, result_valid && $stable(res_bits))
    `ARP_ASSERT_IMPL(a_err_no_store, result_valid && err, no_store)
    `ARP_ASSERT_IMPL(a_store16_masked, st16, st16_ok)
    `ARP_ASSERT_IMPL(a_store32_masked, st32, st32_ok)
    `ARP_ASSERT_IMPL(a_ready_follows, result_ready, entry_ready)

endmodule

bind aarch64_reloc_patch_unit arp_checker u_arp_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .entry_ready        (entry.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_patch_value (result.patch_value),
    .result_store_width (result.store_width),
    .result_status      (result.status)
);
